// ===== hw/rtl/ced_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ced_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 12;

   // Output queue sizing. Two entries must stay free for a decode to commit.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Item kinds on the request channel.
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam logic [CHAR_W-1:0] NEWLINE_RESET = 8'd13;

   // Escape codes with a fixed value.
   localparam logic [VALUE_W-1:0] CODE_L      = 12'd10;
   localparam logic [VALUE_W-1:0] CODE_T      = 12'd9;
   localparam logic [VALUE_W-1:0] CODE_B      = 12'd8;
   localparam logic [VALUE_W-1:0] CODE_V      = 12'd11;
   localparam logic [VALUE_W-1:0] CODE_R      = 12'd13;
   localparam logic [VALUE_W-1:0] CODE_F      = 12'd12;
   localparam logic [VALUE_W-1:0] CODE_CR_ESC = 12'd32;

   // Character codes the decoder recognizes.
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5c;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_N         = 8'h6e;
   localparam logic [CHAR_W-1:0] CH_L         = 8'h6c;
   localparam logic [CHAR_W-1:0] CH_T         = 8'h74;
   localparam logic [CHAR_W-1:0] CH_B         = 8'h62;
   localparam logic [CHAR_W-1:0] CH_V         = 8'h76;
   localparam logic [CHAR_W-1:0] CH_R         = 8'h72;
   localparam logic [CHAR_W-1:0] CH_F         = 8'h66;
   localparam logic [CHAR_W-1:0] CH_X         = 8'h78;
   localparam logic [CHAR_W-1:0] CH_D         = 8'h64;
   localparam logic [CHAR_W-1:0] CH_0         = 8'h30;
   localparam logic [CHAR_W-1:0] CH_7         = 8'h37;
   localparam logic [CHAR_W-1:0] CH_9         = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA        = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF        = 8'h46;
   localparam logic [CHAR_W-1:0] CASE_FOLD    = 8'h5f;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_BSL  = 3'd1,
      MODE_HEX  = 3'd2,
      MODE_DEC  = 3'd3,
      MODE_OCT  = 3'd4
   } mode_type;

   // One result word.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               from_escape;
      logic               last;
   } word_type;

   // Words produced by one decode step, in order; count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      word_type   w0;
      word_type   w1;
   } dec_type;

endpackage

// ===== hw/rtl/ced_core.sv =====
// Escape state registers and the combinational decode of one item.
// Depends on ced_pkg.
`timescale 1ns / 1ps

module ced_core
   import ced_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              action,
   input  logic [CHAR_W-1:0] char_in,
   input  logic [CHAR_W-1:0] newline_code,
   output dec_type           dec
);

   mode_type           mode_ff, mode_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [1:0]         count_ff, count_in;

   logic               is_dec, is_oct, is_hex, is_bsl;
   logic [CHAR_W-1:0]  folded;
   logic [3:0]         hex_val, digit;
   logic               digit_ok, done, numeric;
   logic [VALUE_W-1:0] acc;
   logic [1:0]         cnt_next;

   // Character classes.
   assign is_bsl  = (char_in == CH_BACKSLASH);
   assign is_dec  = char_in inside {[CH_0:CH_9]};
   assign is_oct  = char_in inside {[CH_0:CH_7]};
   assign folded  = char_in & CASE_FOLD;
   assign is_hex  = is_dec || (!char_in[CHAR_W-1] && (folded inside {[CH_UA:CH_UF]}));
   assign hex_val = is_dec ? char_in[3:0] : 4'(folded - CH_UA + 8'd10);

   assign numeric  = (mode_ff == MODE_HEX) || (mode_ff == MODE_DEC) || (mode_ff == MODE_OCT);
   assign cnt_next = count_ff + 2'd1;

   // Digit value, accumulation and completion for the current numeric mode.
   always_comb begin
      digit    = 4'd0;
      digit_ok = 1'b0;
      acc      = value_ff;
      done     = 1'b0;
      case (mode_ff)
         MODE_HEX: begin
            digit    = hex_val;
            digit_ok = is_hex;
            acc      = {value_ff[VALUE_W-5:0], 4'b0} + VALUE_W'(digit);
            done     = (cnt_next >= 2'd2);
         end
         MODE_DEC: begin
            digit    = char_in[3:0];
            digit_ok = is_dec;
            acc      = {value_ff[VALUE_W-4:0], 3'b0} + {value_ff[VALUE_W-2:0], 1'b0}
                       + VALUE_W'(digit);
            done     = (cnt_next == 2'd3);
         end
         MODE_OCT: begin
            digit    = {1'b0, char_in[2:0]};
            digit_ok = is_oct;
            acc      = {value_ff[VALUE_W-4:0], 3'b0} + VALUE_W'(digit);
            done     = (cnt_next == 2'd3);
         end
         default: begin
            digit    = 4'd0;
            digit_ok = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (fire) begin
         if (action == ACT_END) begin
            mode_in  = MODE_IDLE;
            value_in = '0;
            count_in = '0;
         end else begin
            case (mode_ff)
               MODE_BSL: begin
                  mode_in  = MODE_IDLE;
                  value_in = '0;
                  count_in = '0;
                  if (char_in == CH_X) begin
                     mode_in = MODE_HEX;
                  end else if (char_in == CH_D) begin
                     mode_in = MODE_DEC;
                  end else if (is_oct) begin
                     mode_in  = MODE_OCT;
                     value_in = VALUE_W'(char_in[2:0]);
                  end
               end
               MODE_HEX, MODE_DEC, MODE_OCT: begin
                  if (digit_ok && !done) begin
                     value_in = acc;
                     count_in = cnt_next;
                  end else begin
                     value_in = '0;
                     count_in = '0;
                     mode_in  = (!digit_ok && is_bsl) ? MODE_BSL : MODE_IDLE;
                  end
               end
               default: begin
                  value_in = '0;
                  count_in = '0;
                  mode_in  = is_bsl ? MODE_BSL : MODE_IDLE;
               end
            endcase
         end
      end
   end

   // Result words.
   always_comb begin
      dec = '0;
      if (action == ACT_END) begin
         if (numeric) begin
            dec.count = 2'd1;
            dec.w0    = '{value: value_ff, from_escape: 1'b1, last: 1'b1};
         end
      end else begin
         case (mode_ff)
            MODE_BSL: begin
               dec.count = 2'd1;
               dec.w0    = '{value: VALUE_W'(char_in), from_escape: 1'b1, last: 1'b1};
               case (char_in)
                  CH_N:  dec.w0.value = VALUE_W'(newline_code);
                  CH_L:  dec.w0.value = CODE_L;
                  CH_T:  dec.w0.value = CODE_T;
                  CH_B:  dec.w0.value = CODE_B;
                  CH_V:  dec.w0.value = CODE_V;
                  CH_R:  dec.w0.value = CODE_R;
                  CH_F:  dec.w0.value = CODE_F;
                  CH_CR: dec.w0.value = CODE_CR_ESC;
                  CH_X, CH_D: dec.count = 2'd0;
                  default: begin
                     if (is_oct) begin
                        dec.count = 2'd0;
                     end
                  end
               endcase
            end
            MODE_HEX, MODE_DEC, MODE_OCT: begin
               if (digit_ok) begin
                  if (done) begin
                     dec.count = 2'd1;
                     dec.w0    = '{value: acc, from_escape: 1'b1, last: 1'b1};
                  end
               end else begin
                  // Pending value first; a backslash then only opens an escape.
                  dec.w0 = '{value: value_ff, from_escape: 1'b1, last: is_bsl};
                  if (is_bsl) begin
                     dec.count = 2'd1;
                  end else begin
                     dec.count = 2'd2;
                     dec.w1    = '{value: VALUE_W'(char_in), from_escape: 1'b0, last: 1'b1};
                  end
               end
            end
            default: begin
               if (!is_bsl) begin
                  dec.count = 2'd1;
                  dec.w0    = '{value: VALUE_W'(char_in), from_escape: 1'b0, last: 1'b1};
               end
            end
         endcase
      end
      if (!fire) begin
         dec.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         value_ff <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_first_not_last_means_two : assert property (@(posedge clock) disable iff (reset)
      (dec.count != 2'd0 && !dec.w0.last) |-> dec.count == 2'd2)
      else $error("first word without last flag but no second word");

   a_second_is_plain_last : assert property (@(posedge clock) disable iff (reset)
      (dec.count == 2'd2) |-> (!dec.w1.from_escape && dec.w1.last && !is_bsl))
      else $error("second word malformed");

   a_end_goes_idle : assert property (@(posedge clock) disable iff (reset)
      (fire && action == ACT_END) |=> (mode_ff == MODE_IDLE && value_ff == '0))
      else $error("end item did not clear escape state");
`endif

endmodule

// ===== hw/rtl/ced_queue.sv =====
// Result word queue between the decode step and the response channel.
// Depends on ced_pkg.
`timescale 1ns / 1ps

module ced_queue
   import ced_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dec_type            dec,
   output logic               space,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output word_type           head
);

   word_type           mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic [Q_PTR_W-1:0] wr_ptr_1;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign space     = (count_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign head      = mem_ff[rd_ptr_ff];
   assign wr_ptr_1  = wr_ptr_ff + Q_PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + Q_PTR_W'(dec.count);
   assign rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop);
   assign count_in  = count_ff + Q_CNT_W'(dec.count) - Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (dec.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= dec.w0;
      end
      if (dec.count == 2'd2) begin
         mem_ff[wr_ptr_1] <= dec.w1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (dec.count != 2'd0) |-> space)
      else $error("words pushed without room in the queue");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_count_tracks : assert property (@(posedge clock) disable iff (reset)
      !reset |=> count_ff == $past(count_ff) + Q_CNT_W'($past(dec.count))
                 - Q_CNT_W'($past(pop)))
      else $error("queue count does not follow pushes and pops");
`endif

endmodule

// ===== hw/rtl/c_escape_sequence_decoder.sv =====
// Top level of the escape sequence decoder: input register, decode core, result queue.
// Depends on ced_pkg, ced_core and ced_queue.
`timescale 1ns / 1ps

// Decodes the body of a character or string literal, one byte per request
// word. Plain bytes pass through; a backslash opens an escape (n, l, t, b, v,
// r, f, carriage return, x with up to two hex digits, d with up to three
// decimal digits, or an octal digit followed by up to three more). A byte
// other than a backslash that ends a numeric escape early yields two words:
// the pending value, then that byte decoded afresh; a backslash yields the
// pending value alone. An end word (req_action high) flushes a pending
// numeric value. Each request word is captured in an input register, then
// decoded into a four-word result queue, so a request may be taken every
// cycle while the queue has room for two words. The response channel moves
// one word per cycle while rsp_stall is low, which sets the sustained rate:
// one response word per request for ordinary text and two for a request that
// ends a numeric escape with another byte. The n escape value comes from the
// csr register, reset to 13; write it only while no request is in flight.

module c_escape_sequence_decoder
   import ced_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [CHAR_W-1:0]  req_char_in,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value_out,
   output logic               rsp_from_escape,
   output logic               rsp_last,
   // Newline code register.
   input  logic               csr_wr_en,
   input  logic [CHAR_W-1:0]  csr_wr_data
);

   logic              in_valid_ff, in_valid_in;
   logic              in_action_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic [CHAR_W-1:0] newline_ff;
   logic              load, fire, space;
   dec_type           dec;
   word_type          head;

   // The held word is decoded as soon as the queue has room for two results.
   // The input register accepts a new word whenever it is empty or its word is
   // being decoded in this same cycle.
   assign fire        = in_valid_ff && space;
   assign req_stall   = in_valid_ff && !fire;
   assign load        = req_valid && !req_stall;
   assign in_valid_in = load || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         newline_ff  <= NEWLINE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            newline_ff <= csr_wr_data;
         end
      end
   end

   // Payload of the input register needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         in_action_ff <= req_action;
         in_char_ff   <= req_char_in;
      end
   end

   ced_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .action       (in_action_ff),
      .char_in      (in_char_ff),
      .newline_code (newline_ff),
      .dec          (dec)
   );

   ced_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .dec       (dec),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_value_out   = head.value;
   assign rsp_from_escape = head.from_escape;
   assign rsp_last        = head.last;

endmodule

// ===== tb/sv/c_escape_sequence_decoder_tb.sv =====
// Self-checking testbench for c_escape_sequence_decoder: a tracker class predicts every
// response word from accepted requests; a task drives requests, an always block responses.
// Depends on ced_pkg and the c_escape_sequence_decoder RTL.
`timescale 1ns / 1ps

module c_escape_sequence_decoder_tb
   import ced_pkg::*;
();

   // This bound lies far beyond any correct run, so it only catches a hang.
   localparam int CYCLE_LIMIT     = 200000;
   localparam int WORDS_PER_PHASE = 200;
   // A request word that yields no response may still sit in the input register
   // when the last expected word has arrived; this many cycles covers it.
   localparam int SETTLE_CYCLES   = 4;

   // Tracks the decoder state from the accepted request words, and holds the
   // response words that are still due, oldest first.
   class literal_tracker;
      logic [CHAR_W-1:0]  newline;
      mode_type           mode;
      logic [VALUE_W-1:0] acc;
      logic [1:0]         digits;
      word_type           due_words[$];
      int                 error_count;

      function new();
         newline     = NEWLINE_RESET;
         mode        = MODE_IDLE;
         acc         = '0;
         digits      = '0;
         error_count = 0;
      endfunction

      function void set_newline(logic [CHAR_W-1:0] code);
         newline = code;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void due(logic [VALUE_W-1:0] value, logic from_escape, logic last);
         word_type w;
         w.value       = value;
         w.from_escape = from_escape;
         w.last        = last;
         due_words.push_back(w);
      endfunction

      function void clear_escape();
         mode   = MODE_IDLE;
         acc    = '0;
         digits = '0;
      endfunction

      function void close_value(logic last);
         due(acc, 1'b1, last);
         clear_escape();
      endfunction

      // Only 0-9, a-f and A-F count. The top-bit check keeps bytes such as 0xc1
      // from folding onto a letter.
      function int hex_digit(logic [CHAR_W-1:0] c);
         logic [CHAR_W-1:0] folded;
         if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
         if (c[CHAR_W-1]) return -1;
         folded = c & CASE_FOLD;
         if (folded >= CH_UA && folded <= CH_UF) return int'(folded - CH_UA) + 10;
         return -1;
      endfunction

      // Decodes a byte as the start of something new. When it follows a flushed
      // value and is a backslash, that value becomes the final word of the request.
      function void take_fresh(logic [CHAR_W-1:0] c, logic after_value);
         word_type w;
         if (c == CH_BACKSLASH) begin
            mode = MODE_BSL;
            if (after_value) begin
               w = due_words.pop_back();
               w.last = 1'b1;
               due_words.push_back(w);
            end
         end else begin
            mode = MODE_IDLE;
            due(VALUE_W'(c), 1'b0, 1'b1);
         end
      endfunction

      function void ended_early(logic [CHAR_W-1:0] c);
         close_value(1'b0);
         take_fresh(c, 1'b1);
      endfunction

      function void take_request(logic action, logic [CHAR_W-1:0] c);
         int h;
         if (action == ACT_END) begin
            if (mode == MODE_HEX || mode == MODE_DEC || mode == MODE_OCT) close_value(1'b1);
            else clear_escape();
            return;
         end
         case (mode)
            MODE_BSL: begin
               clear_escape();
               case (c)
                  CH_N:  due(VALUE_W'(newline), 1'b1, 1'b1);
                  CH_L:  due(CODE_L, 1'b1, 1'b1);
                  CH_T:  due(CODE_T, 1'b1, 1'b1);
                  CH_B:  due(CODE_B, 1'b1, 1'b1);
                  CH_V:  due(CODE_V, 1'b1, 1'b1);
                  CH_R:  due(CODE_R, 1'b1, 1'b1);
                  CH_F:  due(CODE_F, 1'b1, 1'b1);
                  CH_CR: due(CODE_CR_ESC, 1'b1, 1'b1);
                  CH_X:  mode = MODE_HEX;
                  CH_D:  mode = MODE_DEC;
                  default: begin
                     if (c >= CH_0 && c <= CH_7) begin
                        mode = MODE_OCT;
                        acc  = VALUE_W'(c - CH_0);
                     end else begin
                        due(VALUE_W'(c), 1'b1, 1'b1);
                     end
                  end
               endcase
            end
            MODE_HEX: begin
               h = hex_digit(c);
               if (h < 0) begin
                  ended_early(c);
               end else begin
                  acc = (acc << 4) + VALUE_W'(h);
                  digits++;
                  if (digits == 2'd2) close_value(1'b1);
               end
            end
            MODE_DEC: begin
               if (c < CH_0 || c > CH_9) begin
                  ended_early(c);
               end else begin
                  acc = acc * VALUE_W'(10) + VALUE_W'(c - CH_0);
                  digits++;
                  if (digits == 2'd3) close_value(1'b1);
               end
            end
            MODE_OCT: begin
               if (c < CH_0 || c > CH_7) begin
                  ended_early(c);
               end else begin
                  acc = (acc << 3) + VALUE_W'(c - CH_0);
                  digits++;
                  if (digits == 2'd3) close_value(1'b1);
               end
            end
            default: begin
               acc    = '0;
               digits = '0;
               take_fresh(c, 1'b0);
            end
         endcase
      endfunction

      function void check_response(logic [VALUE_W-1:0] value, logic from_escape, logic last);
         word_type want;
         if (due_words.size() == 0) begin
            $error("response word value_out=%0d arrived with nothing due", value);
            error_count++;
            return;
         end
         want = due_words.pop_front();
         if (value !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, value);
            error_count++;
         end
         if (from_escape !== want.from_escape) begin
            $error("from_escape: expected %0b, got %0b", want.from_escape, from_escape);
            error_count++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            error_count++;
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_action      = ACT_CHAR;
   logic [CHAR_W-1:0]  req_char_in     = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [VALUE_W-1:0] rsp_value_out;
   logic               rsp_from_escape;
   logic               rsp_last;
   logic               csr_wr_en       = 1'b0;
   logic [CHAR_W-1:0]  csr_wr_data     = '0;

   literal_tracker tracker;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int words_sent   = 0;
   int cycle_count  = 0;

   c_escape_sequence_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_out   (rsp_value_out),
      .rsp_from_escape (rsp_from_escape),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Watchdog. A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("c_escape_sequence_decoder_tb: errors");
         $finish;
      end
   end

   // Response side. Outputs are sampled at the rising edge, so they hold the
   // values from before the edge. The stall for the next cycle is drawn at
   // random from the current idle rate, which keeps one assignment per edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tracker.check_response(rsp_value_out, rsp_from_escape, rsp_last);
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Offers one request word and returns at the edge where it is taken. An idle
   // stretch may come first. Valid is never lowered and raised within one edge,
   // and the payload holds steady while the block stalls.
   task automatic send_word(logic action, logic [CHAR_W-1:0] c);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid   <= 1'b1;
      req_action  <= action;
      req_char_in <= c;
      do @(posedge clock); while (req_stall);
      tracker.take_request(action, c);
      words_sent++;
   endtask

   task automatic send_char(logic [CHAR_W-1:0] c);
      send_word(ACT_CHAR, c);
   endtask

   // The block ignores the byte of an end word, so it carries random bits.
   task automatic send_end();
      send_word(ACT_END, CHAR_W'($urandom_range(255)));
   endtask

   // Holds back requests until every due word has come out, then lets the
   // input register empty too. The block is idle afterwards.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the block idle. The tracker picks up the
   // new code at the same edge that the block does.
   task automatic write_newline(logic [CHAR_W-1:0] code);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      tracker.set_newline(code);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] random_hex_char();
      int unsigned n;
      n = $urandom_range(15);
      if (n < 10) return CHAR_W'(CH_0 + n);
      // Setting bit 5 turns an upper-case letter into lower case.
      if ($urandom_range(1) != 0) return CHAR_W'(CH_UA + n - 10) | 8'h20;
      return CHAR_W'(CH_UA + n - 10);
   endfunction

   // What may follow a numeric escape that is not yet full: a random byte (a
   // digit just extends it), a backslash that opens the next escape, an end
   // word that flushes it, or nothing so that the next sequence ends it.
   task automatic maybe_interrupt();
      case ($urandom_range(4))
         0: send_char(CHAR_W'($urandom_range(255)));
         1: send_char(CH_BACKSLASH);
         2: send_end();
         default: ;
      endcase
   endtask

   // One random sequence. Most of them are escapes of random kind and random
   // content; plain bytes and end words fill the rest, and a plain byte can
   // itself be a stray backslash that makes the next sequence an escape body.
   task automatic random_sequence();
      logic [CHAR_W-1:0] letters[8];
      int kind;
      int n;
      letters = '{CH_N, CH_L, CH_T, CH_B, CH_V, CH_R, CH_F, CH_CR};
      kind = $urandom_range(99);
      if (kind < 30) begin
         send_char(CHAR_W'($urandom_range(255)));
      end else if (kind < 38) begin
         send_end();
      end else begin
         send_char(CH_BACKSLASH);
         case ($urandom_range(5))
            0: send_char(letters[$urandom_range(7)]);
            1: send_char(CHAR_W'($urandom_range(255)));
            2: begin
               send_char(CH_X);
               n = $urandom_range(2);
               repeat (n) send_char(random_hex_char());
               if (n < 2) maybe_interrupt();
            end
            3: begin
               send_char(CH_D);
               n = $urandom_range(3);
               repeat (n) send_char(CHAR_W'(CH_0 + $urandom_range(9)));
               if (n < 3) maybe_interrupt();
            end
            4: begin
               send_char(CHAR_W'(CH_0 + $urandom_range(7)));
               n = $urandom_range(3);
               repeat (n) send_char(CHAR_W'(CH_0 + $urandom_range(7)));
               if (n < 3) maybe_interrupt();
            end
            default: send_end();
         endcase
      end
   endtask

   // Now and then the sender waits for the block to drain completely.
   task automatic random_phase();
      int first;
      first = words_sent;
      while (words_sent - first < WORDS_PER_PHASE) begin
         if ($urandom_range(39) == 0) settle();
         random_sequence();
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs with the first idle mix and the newline code
      // still at its reset value.
      req_idle_pct = 28;
      rsp_idle_pct = 85;

      // Plain bytes at both ends of the range.
      send_char(8'h00);
      send_char(8'hff);
      // The n escape with the reset newline code.
      send_char(CH_BACKSLASH);
      send_char(CH_N);
      // Two hex digits in mixed case fill the escape and close it.
      send_char(CH_BACKSLASH);
      send_char(CH_X);
      send_char(CH_F);
      send_char(CH_UF);
      // A byte with the top bit set that would fold onto A is no hex digit:
      // the empty escape yields 0, then the byte passes through.
      send_char(CH_BACKSLASH);
      send_char(CH_X);
      send_char(8'hc1);
      // Four octal sevens reach the largest value the field can hold.
      send_char(CH_BACKSLASH);
      send_char(CH_7);
      send_char(CH_7);
      send_char(CH_7);
      send_char(CH_7);
      // An octal escape cut short by a backslash: the value alone is the final
      // word, and the new escape is dropped by the end word that follows.
      send_char(CH_BACKSLASH);
      send_char(CHAR_W'(CH_0 + 3));
      send_char(CH_BACKSLASH);
      send_end();
      // End with no escape open.
      send_end();
      // A decimal escape with no digits flushed by an end word yields 0.
      send_char(CH_BACKSLASH);
      send_char(CH_D);
      send_end();

      // Random phases, each with its own newline code and idle mix.
      write_newline(8'hff);
      random_phase();

      req_idle_pct = 85;
      rsp_idle_pct = 28;
      write_newline(8'h00);
      random_phase();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_newline(CHAR_W'($urandom_range(255)));
      random_phase();

      settle();
      repeat (8) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("c_escape_sequence_decoder_tb: clean");
      end else begin
         $display("c_escape_sequence_decoder_tb: errors");
      end
      $finish;
   end

endmodule
